// ----- hdl/wio_pkg.sv -----
package wio_pkg;

    // default parameter values
    localparam int POS_WIDTH_DEF     = 48;
    localparam int HEADING_WIDTH_DEF = 32;
    localparam int TRIG_FRAC_DEF     = 15;

    // fixed field widths
    localparam int RAW_WIDTH   = 16;
    localparam int STAMP_WIDTH = 27;
    localparam int CFG_WIDTH   = 15;

    // angle grid in pi/1440 steps
    localparam int TRIG_QUARTER = 720;
    localparam int TRIG_HALF    = 1440;
    localparam int TRIG_3QUART  = 2160;
    localparam int TRIG_FULL    = 2880;
    localparam int TRIG_ADDR_W  = 10;
    localparam int TRIG_IDX_W   = 12;

    // residue of a biased 16-bit delta modulo the full turn
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP       = (1 << RECIP_SHIFT) / TRIG_FULL;
    localparam int BIAS_RES    = (1 << (RAW_WIDTH - 1)) % TRIG_FULL;
    localparam int QUOT_W      = 5;
    localparam int PROD_W      = RAW_WIDTH + QUOT_W + 6;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic {
        REG_PULSE_MODULUS = 1'b0,
        REG_ANGLE_MODULUS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                   neg;
        logic [TRIG_ADDR_W-1:0] addr;
    } trig_addr_t;

    // quarter-wave sine entry k, Taylor series in Q30, rounded to frac bits
    function automatic int trig_entry(int k, int frac);
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        longint      v;
        x    = (64'(k) * PI_Q30 + 64'd720) / 64'd1440;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        v = (sum + (longint'(1) << (29 - frac))) >>> (30 - frac);
        if (v > ((longint'(1) << frac) - 1)) begin
            v = (longint'(1) << frac) - 1;
        end
        return int'(v);
    endfunction

    // 2^(width+1) mod full turn, the jump of twice the heading on a wrap
    function automatic int wrap_residue(int width);
        int r;
        r = 1;
        for (int i = 0; i <= width; i++) begin
            r = (r * 2) % TRIG_FULL;
        end
        return r;
    endfunction

endpackage

// ----- hdl/wheel_imu_odometry_integrator.sv -----
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+------------------------------------
// in        | in_valid  | in_stall  | angle_raw, pulse_raw, stamp_in
// out       | out_valid | out_stall | stamp_out, x_pos, y_pos, heading
// cfg       | cfg_we    | (none)    | cfg_index, cfg_data
//
// seven-stage pipeline, one sample per cycle while the output is not stalled;
// the quarter-wave sine rom with its registered read sets one stage, the trig
// multiply another.
// reset clears all accumulators, the first-sample flag and the pipeline,
// and loads the default moduli.
// a stalled output freezes a stage only when it and every stage after it hold
// a sample, so bubbles are squeezed out and in_stall rises only when every
// stage holds a sample and the output is stalled.
module wheel_imu_odometry_integrator
    import wio_pkg::*;
#(
    parameter int POS_WIDTH      = POS_WIDTH_DEF,
    parameter int HEADING_WIDTH  = HEADING_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [RAW_WIDTH-1:0]     angle_raw,
    input  logic signed [RAW_WIDTH-1:0]     pulse_raw,
    input  logic [STAMP_WIDTH-1:0]          stamp_in,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [STAMP_WIDTH-1:0]          stamp_out,
    output logic signed [POS_WIDTH-1:0]     x_pos,
    output logic signed [POS_WIDTH-1:0]     y_pos,
    output logic signed [HEADING_WIDTH-1:0] heading,

    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [CFG_WIDTH-1:0]            cfg_data
);

    localparam int NSTAGE   = 7;
    localparam int HDG_WRAP = wrap_residue(HEADING_WIDTH);
    localparam int DP_W     = RAW_WIDTH + 1;
    localparam int MAG_W    = TRIG_FRAC_BITS + 1;
    localparam int MUL_W    = DP_W + MAG_W;

    // wrapped difference of two 16-bit counts against a rollover modulus
    function automatic logic signed [RAW_WIDTH-1:0] wrap_delta(
        input logic [RAW_WIDTH-1:0] cur,
        input logic [RAW_WIDTH-1:0] prev,
        input logic [CFG_WIDTH-1:0] modulus
    );
        logic [RAW_WIDTH-1:0] d;
        logic signed [RAW_WIDTH:0] dw;
        logic signed [RAW_WIDTH:0] half;
        logic signed [RAW_WIDTH:0] modx;
        d    = cur - prev;
        dw   = $signed({d[RAW_WIDTH-1], d});
        half = $signed({3'b000, modulus[CFG_WIDTH-1:1]});
        modx = $signed({2'b00, modulus});
        if (dw > half) begin
            dw = dw - modx;
        end else if (dw < -half) begin
            dw = dw + modx;
        end
        return dw[RAW_WIDTH-1:0];
    endfunction

    // split a turn index into quarter-wave address and sign
    function automatic trig_addr_t trig_fold(input logic [TRIG_IDX_W-1:0] idx);
        trig_addr_t res;
        if (idx < TRIG_IDX_W'(TRIG_QUARTER)) begin
            res.neg  = 1'b0;
            res.addr = TRIG_ADDR_W'(idx);
        end else if (idx < TRIG_IDX_W'(TRIG_HALF)) begin
            res.neg  = 1'b0;
            res.addr = TRIG_ADDR_W'(TRIG_IDX_W'(TRIG_HALF) - idx);
        end else if (idx < TRIG_IDX_W'(TRIG_3QUART)) begin
            res.neg  = 1'b1;
            res.addr = TRIG_ADDR_W'(idx - TRIG_IDX_W'(TRIG_HALF));
        end else begin
            res.neg  = 1'b1;
            res.addr = TRIG_ADDR_W'(TRIG_IDX_W'(TRIG_FULL) - idx);
        end
        return res;
    endfunction

    // quarter-wave sine rom, contents fixed at elaboration
    logic [TRIG_FRAC_BITS-1:0] trig_rom [TRIG_QUARTER+1];

    for (genvar k = 0; k <= TRIG_QUARTER; k++) begin : g_rom
        localparam int ENTRY = trig_entry(k, TRIG_FRAC_BITS);
        assign trig_rom[k] = TRIG_FRAC_BITS'(ENTRY);
    end

    // configuration
    logic [CFG_WIDTH-1:0] pulse_mod_reg;
    logic [CFG_WIDTH-1:0] angle_mod_reg;

    // pipeline control
    logic [NSTAGE:1] vld_reg;
    logic [NSTAGE:1] adv;
    logic [NSTAGE:1] ld;

    // sample history and loop state
    logic                           started_reg;
    logic [RAW_WIDTH-1:0]           prev_angle_reg;
    logic [RAW_WIDTH-1:0]           prev_pulse_reg;
    logic signed [HEADING_WIDTH-1:0] heading_reg;
    logic [TRIG_IDX_W-1:0]          twice_hdg_reg;
    logic signed [POS_WIDTH-1:0]    x_acc_reg;
    logic signed [POS_WIDTH-1:0]    y_acc_reg;

    // stage payloads
    logic signed [RAW_WIDTH-1:0]     da1_reg, da2_reg;
    logic signed [RAW_WIDTH-1:0]     dp1_reg, dp2_reg, dp3_reg, dp4_reg;
    logic [QUOT_W-1:0]               quot1_reg;
    logic [TRIG_IDX_W-1:0]           dmod2_reg;
    logic [TRIG_IDX_W-1:0]           idx3_reg;
    trig_addr_t                      sin4_reg, cos4_reg;
    logic [TRIG_FRAC_BITS-1:0]       sin_mag5_reg, cos_mag5_reg;
    logic signed [DP_W-1:0]          dp_sin5_reg, dp_cos5_reg;
    logic signed [MUL_W-1:0]         prod_x6_reg, prod_y6_reg;
    logic signed [HEADING_WIDTH-1:0] hdg3_reg, hdg4_reg, hdg5_reg, hdg6_reg, hdg7_reg;
    logic [STAMP_WIDTH-1:0]          stamp1_reg, stamp2_reg, stamp3_reg, stamp4_reg;
    logic [STAMP_WIDTH-1:0]          stamp5_reg, stamp6_reg, stamp7_reg;

    // stage 1 logic
    logic [RAW_WIDTH-1:0]        angle_cur;
    logic [RAW_WIDTH-1:0]        prev_angle_eff;
    logic [RAW_WIDTH-1:0]        prev_pulse_eff;
    logic signed [RAW_WIDTH-1:0] da1_next;
    logic signed [RAW_WIDTH-1:0] dp1_next;
    logic [RAW_WIDTH-1:0]        bias1;
    logic [PROD_W-1:0]           recip_prod;
    logic [QUOT_W-1:0]           quot1_next;

    // stage 2 logic
    logic [RAW_WIDTH-1:0]   bias2;
    logic [RAW_WIDTH:0]     rem_raw;
    logic [TRIG_IDX_W-1:0]  rem_one;
    logic [TRIG_IDX_W-1:0]  dmod2_next;

    // stage 3 logic
    logic signed [HEADING_WIDTH-1:0] hdg_sum;
    logic                            ov_pos;
    logic                            ov_neg;
    logic [TRIG_IDX_W:0]             idx_sum;
    logic [TRIG_IDX_W-1:0]           idx3_next;
    logic [TRIG_IDX_W+1:0]           tw_sum;
    logic [TRIG_IDX_W-1:0]           tw_red;
    logic [TRIG_IDX_W:0]             tw_neg;
    logic [TRIG_IDX_W-1:0]           twice_hdg_next;

    // stage 4 logic
    logic [TRIG_IDX_W:0]   cos_sum;
    logic [TRIG_IDX_W-1:0] cos_idx;

    // handshake: a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NSTAGE] = !vld_reg[NSTAGE] || !out_stall;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        ld[1] = adv[1] && in_valid;
        for (int k = 2; k <= NSTAGE; k++) begin
            ld[k] = adv[k] && vld_reg[k-1];
        end
    end

    assign in_stall  = !adv[1];
    assign out_valid = vld_reg[NSTAGE];

    // stage 1: wrapped deltas, first sample yields zero deltas
    always_comb
    begin
        angle_cur      = RAW_WIDTH'(0) - angle_raw;
        prev_angle_eff = started_reg ? prev_angle_reg : angle_cur;
        prev_pulse_eff = started_reg ? prev_pulse_reg : pulse_raw;
        da1_next       = wrap_delta(angle_cur, prev_angle_eff, angle_mod_reg);
        dp1_next       = wrap_delta(pulse_raw, prev_pulse_eff, pulse_mod_reg);
        // biased delta times reciprocal of the full turn, may land one low
        bias1          = {~da1_next[RAW_WIDTH-1], da1_next[RAW_WIDTH-2:0]};
        recip_prod     = PROD_W'(bias1) * PROD_W'(RECIP);
        quot1_next     = recip_prod[RECIP_SHIFT +: QUOT_W];
    end

    // stage 2: angle delta modulo the full turn
    always_comb
    begin
        bias2   = {~da1_reg[RAW_WIDTH-1], da1_reg[RAW_WIDTH-2:0]};
        rem_raw = (RAW_WIDTH+1)'(bias2)
                - (RAW_WIDTH+1)'(quot1_reg) * (RAW_WIDTH+1)'(TRIG_FULL);
        if (rem_raw >= (RAW_WIDTH+1)'(TRIG_FULL)) begin
            rem_one = TRIG_IDX_W'(rem_raw - (RAW_WIDTH+1)'(TRIG_FULL));
        end else begin
            rem_one = TRIG_IDX_W'(rem_raw);
        end
        // remove the residue of the bias
        if (rem_one >= TRIG_IDX_W'(BIAS_RES)) begin
            dmod2_next = rem_one - TRIG_IDX_W'(BIAS_RES);
        end else begin
            dmod2_next = rem_one + TRIG_IDX_W'(TRIG_FULL - BIAS_RES);
        end
    end

    // stage 3: heading update, mid-step index, twice-heading residue
    always_comb
    begin
        hdg_sum = heading_reg + HEADING_WIDTH'(da2_reg);
        ov_pos  = !heading_reg[HEADING_WIDTH-1] && !da2_reg[RAW_WIDTH-1]
                && hdg_sum[HEADING_WIDTH-1];
        ov_neg  = heading_reg[HEADING_WIDTH-1] && da2_reg[RAW_WIDTH-1]
                && !hdg_sum[HEADING_WIDTH-1];

        // index = twice heading + delta + quarter turn, mod full turn
        idx_sum = (TRIG_IDX_W+1)'(twice_hdg_reg) + (TRIG_IDX_W+1)'(dmod2_reg)
                + (TRIG_IDX_W+1)'(TRIG_QUARTER);
        if (idx_sum >= (TRIG_IDX_W+1)'(2 * TRIG_FULL)) begin
            idx3_next = TRIG_IDX_W'(idx_sum - (TRIG_IDX_W+1)'(2 * TRIG_FULL));
        end else if (idx_sum >= (TRIG_IDX_W+1)'(TRIG_FULL)) begin
            idx3_next = TRIG_IDX_W'(idx_sum - (TRIG_IDX_W+1)'(TRIG_FULL));
        end else begin
            idx3_next = TRIG_IDX_W'(idx_sum);
        end

        // twice heading advances by twice the delta
        tw_sum = (TRIG_IDX_W+2)'(twice_hdg_reg) + (TRIG_IDX_W+2)'({dmod2_reg, 1'b0});
        if (tw_sum >= (TRIG_IDX_W+2)'(2 * TRIG_FULL)) begin
            tw_red = TRIG_IDX_W'(tw_sum - (TRIG_IDX_W+2)'(2 * TRIG_FULL));
        end else if (tw_sum >= (TRIG_IDX_W+2)'(TRIG_FULL)) begin
            tw_red = TRIG_IDX_W'(tw_sum - (TRIG_IDX_W+2)'(TRIG_FULL));
        end else begin
            tw_red = TRIG_IDX_W'(tw_sum);
        end

        // heading register wrap shifts its residue
        tw_neg = (TRIG_IDX_W+1)'(tw_red) + (TRIG_IDX_W+1)'(HDG_WRAP);
        if (ov_pos) begin
            if (tw_red >= TRIG_IDX_W'(HDG_WRAP)) begin
                twice_hdg_next = tw_red - TRIG_IDX_W'(HDG_WRAP);
            end else begin
                twice_hdg_next = tw_red + TRIG_IDX_W'(TRIG_FULL - HDG_WRAP);
            end
        end else if (ov_neg) begin
            if (tw_neg >= (TRIG_IDX_W+1)'(TRIG_FULL)) begin
                twice_hdg_next = TRIG_IDX_W'(tw_neg - (TRIG_IDX_W+1)'(TRIG_FULL));
            end else begin
                twice_hdg_next = TRIG_IDX_W'(tw_neg);
            end
        end else begin
            twice_hdg_next = tw_red;
        end
    end

    // stage 4: cosine index is a quarter turn ahead
    always_comb
    begin
        cos_sum = (TRIG_IDX_W+1)'(idx3_reg) + (TRIG_IDX_W+1)'(TRIG_QUARTER);
        if (cos_sum >= (TRIG_IDX_W+1)'(TRIG_FULL)) begin
            cos_idx = TRIG_IDX_W'(cos_sum - (TRIG_IDX_W+1)'(TRIG_FULL));
        end else begin
            cos_idx = TRIG_IDX_W'(cos_sum);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pulse_mod_reg <= CFG_WIDTH'(30000);
            angle_mod_reg <= CFG_WIDTH'(3600);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PULSE_MODULUS: pulse_mod_reg <= cfg_data;
                REG_ANGLE_MODULUS: angle_mod_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg        <= '0;
            started_reg    <= 1'b0;
            prev_angle_reg <= '0;
            prev_pulse_reg <= '0;
            heading_reg    <= '0;
            twice_hdg_reg  <= '0;
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
        end else begin
            if (adv[1]) begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (ld[1]) begin
                started_reg    <= 1'b1;
                prev_angle_reg <= angle_cur;
                prev_pulse_reg <= pulse_raw;
            end
            if (ld[3]) begin
                heading_reg   <= hdg_sum;
                twice_hdg_reg <= twice_hdg_next;
            end
            if (ld[NSTAGE]) begin
                x_acc_reg <= x_acc_reg + POS_WIDTH'(prod_x6_reg);
                y_acc_reg <= y_acc_reg + POS_WIDTH'(prod_y6_reg);
            end
        end
    end

    // stage payloads, rom read included
    always_ff @(posedge clk)
    begin
        if (adv[1]) begin
            da1_reg    <= da1_next;
            dp1_reg    <= dp1_next;
            quot1_reg  <= quot1_next;
            stamp1_reg <= stamp_in;
        end
        if (adv[2]) begin
            da2_reg    <= da1_reg;
            dp2_reg    <= dp1_reg;
            dmod2_reg  <= dmod2_next;
            stamp2_reg <= stamp1_reg;
        end
        if (adv[3]) begin
            idx3_reg   <= idx3_next;
            dp3_reg    <= dp2_reg;
            hdg3_reg   <= hdg_sum;
            stamp3_reg <= stamp2_reg;
        end
        if (adv[4]) begin
            sin4_reg   <= trig_fold(idx3_reg);
            cos4_reg   <= trig_fold(cos_idx);
            dp4_reg    <= dp3_reg;
            hdg4_reg   <= hdg3_reg;
            stamp4_reg <= stamp3_reg;
        end
        if (adv[5]) begin
            sin_mag5_reg <= trig_rom[sin4_reg.addr];
            cos_mag5_reg <= trig_rom[cos4_reg.addr];
            dp_sin5_reg  <= sin4_reg.neg ? -DP_W'(dp4_reg) : DP_W'(dp4_reg);
            dp_cos5_reg  <= cos4_reg.neg ? -DP_W'(dp4_reg) : DP_W'(dp4_reg);
            hdg5_reg     <= hdg4_reg;
            stamp5_reg   <= stamp4_reg;
        end
        if (adv[6]) begin
            prod_x6_reg <= MUL_W'(dp_cos5_reg) * MUL_W'($signed({1'b0, cos_mag5_reg}));
            prod_y6_reg <= MUL_W'(dp_sin5_reg) * MUL_W'($signed({1'b0, sin_mag5_reg}));
            hdg6_reg    <= hdg5_reg;
            stamp6_reg  <= stamp5_reg;
        end
        if (adv[NSTAGE]) begin
            hdg7_reg   <= hdg6_reg;
            stamp7_reg <= stamp6_reg;
        end
    end

    assign stamp_out = stamp7_reg;
    assign x_pos     = x_acc_reg;
    assign y_pos     = y_acc_reg;
    assign heading   = hdg7_reg;

endmodule
